// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
// No dependencies; the checker file pulls this header in by `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Clocked assertion that is checked during reset as well.
`define ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// File: hw/rtl/lc2k_pkg.sv
// Shared types, codes and helper functions of the instruction executor.
// No dependencies; used by the top level, the main memory and the register file.
package lc2k_pkg;

  // Item operation codes carried on the slave-side tuser.
  localparam logic [1:0] OP_LOAD_MEM = 2'd0;
  localparam logic [1:0] OP_STEP     = 2'd1;
  localparam logic [1:0] OP_READ_MEM = 2'd2;
  localparam logic [1:0] OP_READ_REG = 2'd3;

  // Instruction opcodes, bits 24..22 of an instruction word.
  localparam logic [2:0] OPC_ADD  = 3'd0;
  localparam logic [2:0] OPC_NAND = 3'd1;
  localparam logic [2:0] OPC_LW   = 3'd2;
  localparam logic [2:0] OPC_SW   = 3'd3;
  localparam logic [2:0] OPC_BEQ  = 3'd4;
  localparam logic [2:0] OPC_JALR = 3'd5;
  localparam logic [2:0] OPC_HALT = 3'd6;
  localparam logic [2:0] OPC_NOOP = 3'd7;

  localparam int REG_COUNT = 8;
  localparam int REG_AW    = 3;
  localparam int WORD_W    = 32;
  localparam int PC_W      = 16;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 120;

  typedef struct packed {
    logic en;
    logic we;
  } mem_ctl_t;

  typedef struct packed {
    logic              re;
    logic [REG_AW-1:0] addr_a;
    logic [REG_AW-1:0] addr_b;
  } rf_rd_t;

  typedef struct packed {
    logic              we;
    logic [REG_AW-1:0] addr;
    logic [WORD_W-1:0] data;
  } rf_wr_t;

  // Weighted cycle cost of one executed instruction.
  function automatic logic [3:0] cycle_weight(input logic [2:0] opc);
    logic [3:0] w;
    unique case (opc) inside
      OPC_ADD, OPC_NAND: w = 4'd2;
      OPC_LW, OPC_SW:    w = 4'd8;
      OPC_BEQ:           w = 4'd4;
      default:           w = 4'd1;
    endcase
    return w;
  endfunction

endpackage

// File: hw/rtl/lc2k_instruction_executor.sv
// Instruction executor top level. Items load a memory word, read a register, read a memory
// word or step the machine (fetch, execute, and for lw and sw a data access; a halted
// machine only returns its state). Addresses pass the registered address reduction when
// MEM_WORDS is not a power of two. One item at a time; the memory port is the pace.
// Reset is synchronous: memory clearing follows, with no item taken.
// Uses lc2k_pkg, lc2k_main_mem, lc2k_reg_file and lc2k_addr_reduce.
module lc2k_instruction_executor #(
  parameter int MEM_WORDS = 65536
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // Fields from bit 0 up: address[15:0], data[47:16].
  input  logic [lc2k_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // Fields from bit 0 up: op[1:0].
  input  logic [1:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // Fields from bit 0 up: pc_value[15:0], halted[16], instruction_total[48:17],
  // cycle_total[80:49], read_word[112:81], zero fill[119:113].
  output logic [lc2k_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  localparam int ADDR_W = $clog2(MEM_WORDS);
  // Pipeline depth of the address reduction unit.
  localparam int REDUCE_LAT = ((MEM_WORDS & (MEM_WORDS - 1)) == 0) ? 0 : 2;

  // Sequencer states.
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ADDR  = 4'd2;
  localparam logic [3:0] S_FETCH = 4'd3;
  localparam logic [3:0] S_EXEC  = 4'd4;
  localparam logic [3:0] S_LWWB  = 4'd5;
  localparam logic [3:0] S_MRD   = 4'd6;
  localparam logic [3:0] S_RRD   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  // Which address feeds the memory in the address state.
  localparam logic [1:0] ASEL_IN = 2'd0;
  localparam logic [1:0] ASEL_PC = 2'd1;
  localparam logic [1:0] ASEL_EA = 2'd2;

  logic [3:0]        state;
  logic [ADDR_W-1:0] clr_cnt;
  logic [1:0]        wait_cnt;
  logic [1:0]        asel;
  logic [1:0]        item_op;
  logic [15:0]       item_addr;
  logic [31:0]       item_data;
  logic [15:0]       pc;
  logic              halted;
  logic [31:0]       instr_total;
  logic [31:0]       cycle_total;
  logic [31:0]       ins;
  logic [15:0]       ea;
  logic [31:0]       rd_word;
  logic              out_valid;
  logic [lc2k_pkg::OUT_DATA_W-1:0] out_data;

  logic              accept;
  logic              addr_ready;
  logic [15:0]       red_addr;
  logic [ADDR_W-1:0] red_idx;

  lc2k_pkg::mem_ctl_t mem_ctl;
  logic [ADDR_W-1:0]  mem_idx;
  logic [31:0]        mem_wdata;
  logic [31:0]        mem_rdata;

  lc2k_pkg::rf_rd_t   rf_rd;
  lc2k_pkg::rf_wr_t   rf_wr;
  logic [31:0]        rf_a;
  logic [31:0]        rf_b;

  // Decoded fields of the current instruction.
  logic [2:0]  opc;
  logic [2:0]  ra_idx;
  logic [2:0]  rb_idx;
  logic [15:0] pc_inc;

  assign opc    = ins[24:22];
  assign ra_idx = ins[21:19];
  assign rb_idx = ins[18:16];
  assign pc_inc = pc + 16'd1;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // The address must stay stable while the reduction unit works on it, which
  // holds because every source is a register that only changes outside S_ADDR.
  assign addr_ready = (wait_cnt == 2'(REDUCE_LAT));

  always_comb begin
    case (asel)
      ASEL_PC: red_addr = pc;
      ASEL_EA: red_addr = ea;
      default: red_addr = item_addr;
    endcase
  end

  lc2k_addr_reduce #(.MEM_WORDS(MEM_WORDS)) u_reduce (
    .clk  (clk),
    .addr (red_addr),
    .idx  (red_idx)
  );

  // Memory and register-file port control. All accesses of one item are
  // sequenced, so no read ever overlaps a write to the same entry.
  always_comb begin
    mem_ctl   = '0;
    mem_idx   = red_idx;
    mem_wdata = item_data;
    rf_rd     = '0;
    rf_wr     = '0;
    unique case (state)
      S_CLEAR: begin
        mem_ctl.en = 1'b1;
        mem_ctl.we = 1'b1;
        mem_idx    = clr_cnt;
        mem_wdata  = '0;
      end
      S_IDLE: begin
        if (accept && (s_axis_tuser == lc2k_pkg::OP_READ_REG)) begin
          rf_rd.re     = 1'b1;
          rf_rd.addr_a = s_axis_tdata[2:0];
        end
      end
      S_ADDR: begin
        if (addr_ready) begin
          mem_ctl.en = 1'b1;
          mem_ctl.we = (item_op == lc2k_pkg::OP_LOAD_MEM) ||
                       ((asel == ASEL_EA) && (opc == lc2k_pkg::OPC_SW));
          // A store writes the regA value read during fetch.
          mem_wdata  = (item_op == lc2k_pkg::OP_LOAD_MEM) ? item_data : rf_a;
        end
      end
      S_FETCH: begin
        rf_rd.re     = 1'b1;
        rf_rd.addr_a = mem_rdata[21:19];
        rf_rd.addr_b = mem_rdata[18:16];
      end
      S_EXEC: begin
        unique case (opc) inside
          lc2k_pkg::OPC_ADD: begin
            rf_wr.we   = 1'b1;
            rf_wr.addr = ins[2:0];
            rf_wr.data = rf_a + rf_b;
          end
          lc2k_pkg::OPC_NAND: begin
            rf_wr.we   = 1'b1;
            rf_wr.addr = ins[2:0];
            rf_wr.data = ~(rf_a & rf_b);
          end
          lc2k_pkg::OPC_JALR: begin
            rf_wr.we   = 1'b1;
            rf_wr.addr = ra_idx;
            rf_wr.data = {16'd0, pc_inc};
          end
          default: begin
          end
        endcase
      end
      S_LWWB: begin
        rf_wr.we   = 1'b1;
        rf_wr.addr = ra_idx;
        rf_wr.data = mem_rdata;
      end
      default: begin
      end
    endcase
  end

  lc2k_main_mem #(.MEM_WORDS(MEM_WORDS)) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .idx   (mem_idx),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  lc2k_reg_file u_rf (
    .clk     (clk),
    .rst     (rst),
    .rd      (rf_rd),
    .wr      (rf_wr),
    .rdata_a (rf_a),
    .rdata_b (rf_b)
  );

  // Control sequencer and architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_cnt     <= '0;
      wait_cnt    <= '0;
      asel        <= ASEL_IN;
      pc          <= '0;
      halted      <= 1'b0;
      instr_total <= '0;
      cycle_total <= '0;
      out_valid   <= 1'b0;
    end else begin
      // The output register fills from S_DONE and empties on a result transfer.
      if ((state == S_DONE) && (!out_valid || m_axis_tready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == ADDR_W'(MEM_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            item_op   <= s_axis_tuser;
            item_addr <= s_axis_tdata[15:0];
            item_data <= s_axis_tdata[47:16];
            rd_word   <= '0;
            wait_cnt  <= '0;
            // A step fetches at the pc; every other item uses its own address.
            asel      <= (s_axis_tuser == lc2k_pkg::OP_STEP) ? ASEL_PC : ASEL_IN;
            unique case (s_axis_tuser)
              lc2k_pkg::OP_STEP: begin
                // A halted machine ignores further steps.
                state <= halted ? S_DONE : S_ADDR;
              end
              lc2k_pkg::OP_READ_REG: state <= S_RRD;
              default:               state <= S_ADDR;
            endcase
          end
        end
        S_ADDR: begin
          if (!addr_ready) begin
            wait_cnt <= wait_cnt + 2'd1;
          end else if (item_op == lc2k_pkg::OP_STEP) begin
            if (asel == ASEL_PC) begin
              state <= S_FETCH;
            end else if (opc == lc2k_pkg::OPC_LW) begin
              state <= S_LWWB;
            end else begin
              state <= S_DONE;
            end
          end else if (item_op == lc2k_pkg::OP_READ_MEM) begin
            state <= S_MRD;
          end else begin
            state <= S_DONE;
          end
        end
        S_FETCH: begin
          ins   <= mem_rdata;
          state <= S_EXEC;
        end
        S_EXEC: begin
          instr_total <= instr_total + 32'd1;
          cycle_total <= cycle_total + 32'(lc2k_pkg::cycle_weight(opc));
          unique case (opc) inside
            lc2k_pkg::OPC_HALT: begin
              // Halt leaves the pc on the halt instruction.
              halted <= 1'b1;
              state  <= S_DONE;
            end
            lc2k_pkg::OPC_BEQ: begin
              pc    <= (rf_a == rf_b) ? pc_inc + ins[15:0] : pc_inc;
              state <= S_DONE;
            end
            lc2k_pkg::OPC_JALR: begin
              // With regA equal to regB the jump sees the freshly linked pc+1.
              pc    <= (ra_idx == rb_idx) ? pc_inc : rf_b[15:0];
              state <= S_DONE;
            end
            lc2k_pkg::OPC_LW, lc2k_pkg::OPC_SW: begin
              pc       <= pc_inc;
              ea       <= rf_b[15:0] + ins[15:0];
              asel     <= ASEL_EA;
              wait_cnt <= '0;
              state    <= S_ADDR;
            end
            default: begin
              pc    <= pc_inc;
              state <= S_DONE;
            end
          endcase
        end
        S_LWWB: state <= S_DONE;
        S_MRD: begin
          rd_word <= mem_rdata;
          state   <= S_DONE;
        end
        S_RRD: begin
          rd_word <= rf_a;
          state   <= S_DONE;
        end
        S_DONE: begin
          // The output register takes the result once it is free.
          if (!out_valid || m_axis_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result payload; no reset needed.
  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!out_valid || m_axis_tready)) begin
      out_data <= {7'd0, rd_word, cycle_total, instr_total, halted, pc};
    end
  end

endmodule

// File: hw/rtl/lc2k_main_mem.sv
// Single-port synchronous main memory with registered read data.
// Depends on lc2k_pkg for the control struct.
module lc2k_main_mem #(
  parameter int MEM_WORDS = 65536
) (
  input  logic                          clk,
  input  lc2k_pkg::mem_ctl_t            ctl,
  input  logic [$clog2(MEM_WORDS)-1:0]  idx,
  input  logic [lc2k_pkg::WORD_W-1:0]   wdata,
  output logic [lc2k_pkg::WORD_W-1:0]   rdata
);

  logic [lc2k_pkg::WORD_W-1:0] mem [MEM_WORDS];

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      if (ctl.we) begin
        mem[idx] <= wdata;
      end else begin
        rdata <= mem[idx];
      end
    end
  end

endmodule

// File: hw/rtl/lc2k_reg_file.sv
// Eight-entry register file: two registered read ports, one write port.
// Depends on lc2k_pkg; per-entry valid bits make unwritten entries read zero.
module lc2k_reg_file (
  input  logic                        clk,
  input  logic                        rst,
  input  lc2k_pkg::rf_rd_t            rd,
  input  lc2k_pkg::rf_wr_t            wr,
  output logic [lc2k_pkg::WORD_W-1:0] rdata_a,
  output logic [lc2k_pkg::WORD_W-1:0] rdata_b
);

  logic [lc2k_pkg::WORD_W-1:0]    regs [lc2k_pkg::REG_COUNT];
  logic [lc2k_pkg::REG_COUNT-1:0] valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.we) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we) begin
      regs[wr.addr] <= wr.data;
    end
    if (rd.re) begin
      rdata_a <= valid[rd.addr_a] ? regs[rd.addr_a] : '0;
      rdata_b <= valid[rd.addr_b] ? regs[rd.addr_b] : '0;
    end
  end

endmodule

// File: hw/rtl/lc2k_addr_reduce.sv
// Reduces a 16-bit word address modulo the memory depth.
// Depends on nothing else; for a power-of-two depth it is a mask, otherwise
// a two-stage reciprocal multiply and remainder.
module lc2k_addr_reduce #(
  parameter int MEM_WORDS = 65536
) (
  input  logic                         clk,
  input  logic [15:0]                  addr,
  output logic [$clog2(MEM_WORDS)-1:0] idx
);

  localparam int ADDR_W = $clog2(MEM_WORDS);

  if ((MEM_WORDS & (MEM_WORDS - 1)) == 0) begin : g_pow2
    assign idx = addr[ADDR_W-1:0];
  end else begin : g_recip
    // ceil(2^32 / depth) gives the exact quotient for every 16-bit address.
    localparam longint unsigned RECIP = ((64'd1 << 32) + MEM_WORDS - 1) / MEM_WORDS;
    localparam int RW = $clog2(RECIP + 1);
    localparam int QW = 17 - ADDR_W;
    localparam int PW = 16 + RW;

    logic [PW-1:0] prod;
    logic [QW-1:0] quot;
    logic [15:0]   addr_r;
    logic [15:0]   qd;

    assign prod = PW'(addr) * PW'(RECIP);
    assign qd   = 16'(16'(quot) * 16'(MEM_WORDS));

    always_ff @(posedge clk) begin
      quot   <= QW'(prod >> 32);
      addr_r <= addr;
      idx    <= ADDR_W'(addr_r - qd);
    end
  end

endmodule

// File: hw/rtl/lc2k_checker.sv
// Port-level checker for the instruction executor, with its bind statement.
// Depends on assert_macros.svh and on the top level's port names.
`include "assert_macros.svh"

module lc2k_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [47:0]  s_axis_tdata,
  input logic [1:0]   s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [119:0] m_axis_tdata
);

  logic        out_xfer;
  logic        seen;
  logic        halt_seen;
  logic [31:0] last_instr;

  assign out_xfer = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen       <= 1'b0;
      halt_seen  <= 1'b0;
      last_instr <= '0;
    end else if (out_xfer) begin
      seen       <= 1'b1;
      halt_seen  <= halt_seen | m_axis_tdata[16];
      last_instr <= m_axis_tdata[48:17];
    end
  end

  `ASSERT_CLK(a_reset_quiet, clk, rst |=> (!s_axis_tready && !m_axis_tvalid))
  `ASSERT_CLK_RST(a_out_hold, clk, rst, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
  `ASSERT_CLK_RST(a_halt_sticky, clk, rst, (out_xfer && halt_seen) |-> m_axis_tdata[16])
  `ASSERT_CLK_RST(a_count_step, clk, rst, (out_xfer && seen) |-> ((m_axis_tdata[48:17] == last_instr) || (m_axis_tdata[48:17] == last_instr + 32'd1)))
  `ASSERT_CLK_RST(a_halt_frozen, clk, rst, (out_xfer && halt_seen) |-> (m_axis_tdata[48:17] == last_instr))

endmodule

bind lc2k_instruction_executor lc2k_checker u_checker (.*);
